[design/hptd_pkg.sv]
package hptd_pkg;

  localparam int HYST_BITS        = 16;
  localparam int EVENT_INDEX_BITS = 32;

  localparam logic [HYST_BITS-1:0] HYST_RESET = 16'd1024;

  // event_kind codes
  localparam logic EV_PEAK   = 1'b0;
  localparam logic EV_TROUGH = 1'b1;

endpackage

[design/hysteresis_peak_trough_detector.sv]
// An accepted sample reaches its peak/trough request at the output through the input register
//   and then the result register.
// Throughput: one sample per cycle; the single decision stage between the two registers
//   and the 1-entry result register set this, stalling only when a new event meets a full output.
// Reset (rst, synchronous): mode undecided, no sample seen, index 0, hysteresis 1024, no request.
module hysteresis_peak_trough_detector #(
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration
  input  logic                                   hysteresis_wr_en,
  input  logic [hptd_pkg::HYST_BITS-1:0]         hysteresis_wr_data,
  // sample channel
  input  logic                                   sample_valid,
  output logic                                   sample_ready,
  input  logic signed [SAMPLE_BITS-1:0]          sample,
  // event channel
  output logic                                   event_valid,
  input  logic                                   event_ready,
  output logic                                   event_kind,
  output logic [hptd_pkg::EVENT_INDEX_BITS-1:0]  event_index
);

  import hptd_pkg::*;

  // Compare width: holds s + hysteresis and min + hysteresis without overflow.
  localparam int WIDE_BITS = ((SAMPLE_BITS > HYST_BITS) ? SAMPLE_BITS : HYST_BITS) + 2;

  typedef enum logic [1:0] {
    MODE_UNDECIDED = 2'd0,
    MODE_RISING    = 2'd1,
    MODE_FALLING   = 2'd2
  } mode_t;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [HYST_BITS-1:0] hysteresis;

  always_ff @(posedge clk) begin
    if (rst) begin
      hysteresis <= HYST_RESET;
    end else if (hysteresis_wr_en) begin
      hysteresis <= hysteresis_wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                          in_valid;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          advance;   // stage consumes its sample this cycle

  assign sample_ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample_ready) begin
      in_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready && sample_valid) begin
      in_sample <= sample;
    end
  end

  // ---------------------------------------------------------------------------
  // Tracking state
  // ---------------------------------------------------------------------------
  mode_t                         mode, mode_next;
  logic                          first_seen;
  logic [INDEX_BITS-1:0]         sample_count;
  logic signed [SAMPLE_BITS-1:0] max_value, max_value_next;
  logic signed [SAMPLE_BITS-1:0] min_value, min_value_next;
  logic [INDEX_BITS-1:0]         max_index, max_index_next;
  logic [INDEX_BITS-1:0]         min_index, min_index_next;

  logic                          evt;
  logic                          evt_kind;
  logic [INDEX_BITS-1:0]         evt_index;

  logic signed [WIDE_BITS-1:0]   s_w, e_w, max_w, min_w;
  logic signed [SAMPLE_BITS-1:0] cur_max, cur_min;
  logic [INDEX_BITS-1:0]         cur_max_idx, cur_min_idx;
  logic                          max_le_s, max_ge_s_e, s_le_min, s_ge_min_e;

  // First sample seeds both extremes before the mode rules run.
  always_comb begin
    cur_max     = first_seen ? max_value : in_sample;
    cur_min     = first_seen ? min_value : in_sample;
    cur_max_idx = first_seen ? max_index : sample_count;
    cur_min_idx = first_seen ? min_index : sample_count;
  end

  // Widened compares, no saturation.
  assign s_w   = WIDE_BITS'(in_sample);
  assign e_w   = WIDE_BITS'($signed({1'b0, hysteresis}));
  assign max_w = WIDE_BITS'(cur_max);
  assign min_w = WIDE_BITS'(cur_min);

  assign max_le_s   = max_w <= s_w;
  assign max_ge_s_e = max_w >= s_w + e_w;
  assign s_le_min   = s_w <= min_w;
  assign s_ge_min_e = s_w >= min_w + e_w;

  always_comb begin
    mode_next      = mode;
    max_value_next = cur_max;
    max_index_next = cur_max_idx;
    min_value_next = cur_min;
    min_index_next = cur_min_idx;
    evt            = 1'b0;
    evt_kind       = EV_PEAK;
    evt_index      = cur_max_idx;

    case (mode)
      MODE_RISING: begin
        if (max_le_s) begin
          max_value_next = in_sample;
          max_index_next = sample_count;
        end else if (max_ge_s_e) begin
          // dropped far enough below the held max: confirm peak
          evt            = 1'b1;
          evt_kind       = EV_PEAK;
          evt_index      = cur_max_idx;
          min_value_next = in_sample;
          min_index_next = sample_count;
          mode_next      = MODE_FALLING;
        end
      end
      MODE_FALLING: begin
        if (s_le_min) begin
          min_value_next = in_sample;
          min_index_next = sample_count;
        end else if (s_ge_min_e) begin
          // rose far enough above the held min: confirm trough
          evt            = 1'b1;
          evt_kind       = EV_TROUGH;
          evt_index      = cur_min_idx;
          max_value_next = in_sample;
          max_index_next = sample_count;
          mode_next      = MODE_RISING;
        end
      end
      default: begin
        // undecided (and the unreachable code 3): pick a direction, track extremes
        if (max_ge_s_e) begin
          mode_next = MODE_FALLING;
        end else if (s_ge_min_e) begin
          mode_next = MODE_RISING;
        end
        if (max_le_s) begin
          max_value_next = in_sample;
          max_index_next = sample_count;
        end else if (s_le_min) begin
          min_value_next = in_sample;
          min_index_next = sample_count;
        end
      end
    endcase
  end

  // Hold the stage only when it would emit into a full, stalled output.
  assign advance = in_valid && (!evt || !event_valid || event_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_UNDECIDED;
      first_seen   <= 1'b0;
      sample_count <= '0;
    end else if (advance) begin
      mode         <= mode_next;
      first_seen   <= 1'b1;
      sample_count <= sample_count + INDEX_BITS'(1);  // wraps at 2^INDEX_BITS
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      max_value <= max_value_next;
      max_index <= max_index_next;
      min_value <= min_value_next;
      min_index <= min_index_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (advance && evt) begin
      event_valid <= 1'b1;
    end else if (event_ready) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && evt) begin
      event_kind  <= evt_kind;
      event_index <= EVENT_INDEX_BITS'(evt_index);  // held index, zero-extended or cut to its low bits
    end
  end

endmodule
